@@ sv/tbap_pkg.sv @@
`default_nettype none
package tbap_pkg;

	localparam int TIME_W = 32;
	localparam int REG_W  = 16;
	localparam int IDX_W  = 3;
	localparam int PAGE_OUT_W = 3;

	// register map
	localparam logic [IDX_W-1:0] REG_SCAN_PERIOD   = 3'd0;
	localparam logic [IDX_W-1:0] REG_COMBO_HOLD    = 3'd1;
	localparam logic [IDX_W-1:0] REG_REPEAT_START  = 3'd2;
	localparam logic [IDX_W-1:0] REG_REPEAT_FAST   = 3'd3;
	localparam logic [IDX_W-1:0] REG_REPEAT_SLOW   = 3'd4;
	localparam logic [IDX_W-1:0] REG_MODE_COOLDOWN = 3'd5;

	localparam logic [REG_W-1:0] RST_SCAN_PERIOD   = 16'd35;
	localparam logic [REG_W-1:0] RST_COMBO_HOLD    = 16'd3000;
	localparam logic [REG_W-1:0] RST_REPEAT_START  = 16'd800;
	localparam logic [REG_W-1:0] RST_REPEAT_FAST   = 16'd150;
	localparam logic [REG_W-1:0] RST_REPEAT_SLOW   = 16'd320;
	localparam logic [REG_W-1:0] RST_MODE_COOLDOWN = 16'd1500;

	typedef struct packed {
		logic [REG_W-1:0] scan_period;
		logic [REG_W-1:0] combo_hold;
		logic [REG_W-1:0] repeat_start;
		logic [REG_W-1:0] repeat_fast;
		logic [REG_W-1:0] repeat_slow;
		logic [REG_W-1:0] mode_cooldown;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              next_pressed;
		logic              prev_pressed;
	} sample_t;

	typedef struct packed {
		logic                  scan_taken;
		logic [PAGE_OUT_W-1:0] page_index;
		logic                  mode_toggle;
	} result_t;

	// true when now - since (wrapping) reaches the 16-bit limit
	function automatic logic elapsed_ge(input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] since, input logic [REG_W-1:0] limit);
		logic [TIME_W-1:0] diff;
		diff = now - since;
		return diff >= {{(TIME_W-REG_W){1'b0}}, limit};
	endfunction

endpackage
`default_nettype wire

@@ sv/tbap_cfg_regs.sv @@
`default_nettype none
module tbap_cfg_regs
	import tbap_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scan_period   <= RST_SCAN_PERIOD;
			cfg_q.combo_hold    <= RST_COMBO_HOLD;
			cfg_q.repeat_start  <= RST_REPEAT_START;
			cfg_q.repeat_fast   <= RST_REPEAT_FAST;
			cfg_q.repeat_slow   <= RST_REPEAT_SLOW;
			cfg_q.mode_cooldown <= RST_MODE_COOLDOWN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_PERIOD:   cfg_q.scan_period   <= cfg_wdata;
				REG_COMBO_HOLD:    cfg_q.combo_hold    <= cfg_wdata;
				REG_REPEAT_START:  cfg_q.repeat_start  <= cfg_wdata;
				REG_REPEAT_FAST:   cfg_q.repeat_fast   <= cfg_wdata;
				REG_REPEAT_SLOW:   cfg_q.repeat_slow   <= cfg_wdata;
				REG_MODE_COOLDOWN: cfg_q.mode_cooldown <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

@@ sv/tbap_engine.sv @@
`default_nettype none
module tbap_engine
	import tbap_pkg::*;
#(
	parameter int PAGE_TOTAL = 8
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    take,
	input  wire sample_t smp,
	input  wire cfg_t    cfg,
	output result_t      res
);

	localparam int PW = (PAGE_TOTAL > 1) ? $clog2(PAGE_TOTAL) : 1;
	localparam logic [PW-1:0] PAGE_LAST = PW'(PAGE_TOTAL - 1);

	logic [TIME_W-1:0] last_scan_q, last_page_q, last_mode_q;
	logic [TIME_W-1:0] next_start_q, prev_start_q, combo_start_q;
	logic              next_act_q, prev_act_q, combo_act_q, toggle_done_q;
	logic [PW-1:0]     page_q;

	logic [TIME_W-1:0] next_start_d, prev_start_d, combo_start_d;
	logic [TIME_W-1:0] last_page_d, last_mode_d;
	logic              next_act_d, prev_act_d, combo_act_d, toggle_done_d;
	logic [PW-1:0]     page_d;
	logic              taken, toggle, step_ok;
	logic [REG_W-1:0]  step_iv;
	logic [TIME_W-1:0] hold_start;
	logic [PAGE_OUT_W:0] page_wide;

	always_comb begin
		taken         = elapsed_ge(smp.now_ms, last_scan_q, cfg.scan_period);
		toggle        = 1'b0;
		next_start_d  = next_start_q;
		prev_start_d  = prev_start_q;
		combo_start_d = combo_start_q;
		last_page_d   = last_page_q;
		last_mode_d   = last_mode_q;
		next_act_d    = next_act_q;
		prev_act_d    = prev_act_q;
		combo_act_d   = combo_act_q;
		toggle_done_d = toggle_done_q;
		page_d        = page_q;
		step_ok       = 1'b0;
		step_iv       = cfg.repeat_slow;
		hold_start    = smp.now_ms;

		if (smp.next_pressed && smp.prev_pressed) begin
			next_act_d = 1'b0;
			prev_act_d = 1'b0;
			if (!combo_act_q) begin
				combo_act_d   = 1'b1;
				combo_start_d = smp.now_ms;
				toggle_done_d = 1'b0;
			end
			if (!toggle_done_d &&
					elapsed_ge(smp.now_ms, combo_start_d, cfg.combo_hold) &&
					elapsed_ge(smp.now_ms, last_mode_q, cfg.mode_cooldown)) begin
				toggle        = 1'b1;
				page_d        = '0;
				last_mode_d   = smp.now_ms;
				toggle_done_d = 1'b1;
			end
		end else begin
			combo_act_d   = 1'b0;
			toggle_done_d = 1'b0;
			next_act_d    = smp.next_pressed;
			prev_act_d    = smp.prev_pressed;
			// at most one button here, so one shared repeat check
			if (smp.next_pressed) begin
				if (next_act_q) hold_start = next_start_q;
				next_start_d = hold_start;
			end
			if (smp.prev_pressed) begin
				if (prev_act_q) hold_start = prev_start_q;
				prev_start_d = hold_start;
			end
			if ((smp.now_ms - hold_start) > {{(TIME_W-REG_W){1'b0}}, cfg.repeat_start})
				step_iv = cfg.repeat_fast;
			step_ok = (smp.next_pressed || smp.prev_pressed) &&
				elapsed_ge(smp.now_ms, last_page_q, step_iv);
			if (step_ok) begin
				last_page_d = smp.now_ms;
				if (smp.next_pressed)
					page_d = (page_q == PAGE_LAST) ? '0 : page_q + 1'b1;
				else
					page_d = (page_q == '0) ? PAGE_LAST : page_q - 1'b1;
			end
		end

		// a skipped sample leaves everything as it was
		if (!taken) begin
			toggle = 1'b0;
			page_d = page_q;
		end
		page_wide = (PAGE_OUT_W + 1)'(page_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scan_q   <= '0;
			last_page_q   <= '0;
			last_mode_q   <= '0;
			next_start_q  <= '0;
			prev_start_q  <= '0;
			combo_start_q <= '0;
			next_act_q    <= 1'b0;
			prev_act_q    <= 1'b0;
			combo_act_q   <= 1'b0;
			toggle_done_q <= 1'b0;
			page_q        <= '0;
		end else if (take && taken) begin
			last_scan_q   <= smp.now_ms;
			last_page_q   <= last_page_d;
			last_mode_q   <= last_mode_d;
			next_start_q  <= next_start_d;
			prev_start_q  <= prev_start_d;
			combo_start_q <= combo_start_d;
			next_act_q    <= next_act_d;
			prev_act_q    <= prev_act_d;
			combo_act_q   <= combo_act_d;
			toggle_done_q <= toggle_done_d;
			page_q        <= page_d;
		end
	end

	assign res = '{scan_taken: taken, page_index: page_wide[PAGE_OUT_W-1:0],
		mode_toggle: toggle};

endmodule
`default_nettype wire

@@ sv/two_button_autorepeat_pager_core.sv @@
// Two-button pager with auto-repeat and a both-held mode toggle.
//
// Input channel (in_valid/in_ready): one word per sample, carrying a free
// running millisecond timestamp now_ms and the two button levels.
// Output channel (out_valid/out_ready): exactly one word per sample:
// scan_taken, page_index and a one-sample mode_toggle pulse.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the
// clock edge; indexes past the last register are ignored. Write only
// while no sample is in flight.
//
// Pipeline: a sample accepted into the input register is evaluated against
// the tracker state and lands in the output register when it advances.
// Throughput: one sample per cycle while out_ready is high; the state
// update is a single pass of 32-bit subtract-and-compare logic between
// the two registers.
// Stall: while out_ready is low the output word holds and the input
// register holds one more sample; in_ready drops only when both are full.
// Reset: arst_n clears the valid flags of both registers and the tracker
// state (times zero, no holds, page 0), and loads the default register values.
`default_nettype none
module two_button_autorepeat_pager_core
	import tbap_pkg::*;
#(
	parameter int PAGE_TOTAL = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [TIME_W-1:0]     now_ms,
	input  wire logic                  next_pressed,
	input  wire logic                  prev_pressed,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       scan_taken,
	output logic [PAGE_OUT_W-1:0]      page_index,
	output logic                       mode_toggle,
	input  wire logic                  cfg_we,
	input  wire logic [IDX_W-1:0]      cfg_index,
	input  wire logic [REG_W-1:0]      cfg_wdata
);

	cfg_t    cfg;
	sample_t smp_s1;
	logic    valid_s1;
	result_t res, res_s2;
	logic    valid_s2;
	logic    advance;

	tbap_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			smp_s1 <= '{now_ms: now_ms, next_pressed: next_pressed,
				prev_pressed: prev_pressed};
		end
	end

	tbap_engine #(
		.PAGE_TOTAL (PAGE_TOTAL)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign out_valid   = valid_s2;
	assign scan_taken  = res_s2.scan_taken;
	assign page_index  = res_s2.page_index;
	assign mode_toggle = res_s2.mode_toggle;

	a_toggle_needs_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_toggle |-> scan_taken)
		else $error("mode toggle on a skipped sample");

	a_toggle_clears_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode_toggle |-> page_index == '0)
		else $error("mode toggle without page reset");

	a_ready_when_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_page_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(page_index) < PAGE_TOTAL)
		else $error("page index out of range");

endmodule
`default_nettype wire
